// ===== rtl/core/scl_pkg.sv =====
// Shared constants and types for the servo command line parser.
package scl_pkg;

  // Servo channels accepted in the header, and the angle clamp.
  localparam int unsigned SERVO_COUNT = 3;
  localparam logic [7:0]  ANGLE_MAX   = 8'd180;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_S     = 8'h53;

  // Highest servo digit character allowed in the header.
  localparam logic [7:0] CH_SERVO_HI = 8'(32'(CH_ZERO) + SERVO_COUNT);

  // Number reader phase.
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

endpackage

// ===== rtl/core/servo_command_line_parser_core.sv =====
// Servo command line parser: byte stream in, servo number and angle out.
//
//   channel   dir  handshake               payload
//   in_       in   in_tvalid / in_tready   in_tdata[7:0]  rx_byte
//   out_      out  out_tvalid / out_tready out_tdata[1:0] servo_number, [9:2] angle_value
//
// One byte is taken per cycle while in_tready is high; all line state updates in that cycle.
// A line terminator's result is registered into the head word, or into the skid word when the head is held.
// Results queue in a two-word output buffer; in_tready drops only while both
// words are held, so a single stalled result does not stop the input.
// rst_n is synchronous and active low; it clears the line state and the buffer.
module servo_command_line_parser_core #(
  parameter int unsigned BUFFER_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] servo_number, [9:2] angle_value, [15:10] zero
);

  localparam int unsigned CNT_W = $clog2(BUFFER_SIZE);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_SIZE - 1);

  // Line state.
  logic [CNT_W-1:0]     line_count_r, line_count_nxt;
  logic                 header_ok_r, header_ok_nxt;
  logic [1:0]           servo_digit_r, servo_digit_nxt;
  scl_pkg::phase_t      phase_r, phase_nxt;
  logic                 is_negative_r, is_negative_nxt;
  logic [7:0]           digit_value_r, digit_value_nxt;
  logic                 string_ended_r, string_ended_nxt;

  // Output buffer: head word on the port and one skid word behind it.
  logic                 out_valid_r;
  logic [1:0]           out_servo_r;
  logic [7:0]           out_angle_r;
  logic                 skid_valid_r;
  logic [1:0]           skid_servo_r;
  logic [7:0]           skid_angle_r;

  logic                 accept;
  logic                 pop;
  logic                 push;
  logic [7:0]           c;
  logic                 is_term;
  logic                 is_digit;
  logic                 is_blank;
  logic [11:0]          acc;
  logic [7:0]           digit_sat;
  logic [7:0]           res_angle;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;
  assign c         = in_tdata;

  assign is_term  = (c == scl_pkg::CH_LF) || (c == scl_pkg::CH_CR);
  assign is_digit = (c >= scl_pkg::CH_ZERO) && (c <= scl_pkg::CH_NINE);
  assign is_blank = (c == scl_pkg::CH_SPACE) || (c == scl_pkg::CH_TAB) ||
                    (c == scl_pkg::CH_VT) || (c == scl_pkg::CH_FF);

  // Saturating decimal accumulate.
  assign acc       = 12'(digit_value_r) * 12'd10 + 12'(c[3:0]);
  assign digit_sat = (acc > 12'(scl_pkg::ANGLE_MAX)) ? scl_pkg::ANGLE_MAX : acc[7:0];

  assign res_angle = is_negative_r ? 8'd0 : digit_value_r;
  assign push      = accept && is_term && (line_count_r != '0) && header_ok_r &&
                     (line_count_r >= CNT_W'(3));

  always_comb begin
    line_count_nxt   = line_count_r;
    header_ok_nxt    = header_ok_r;
    servo_digit_nxt  = servo_digit_r;
    phase_nxt        = phase_r;
    is_negative_nxt  = is_negative_r;
    digit_value_nxt  = digit_value_r;
    string_ended_nxt = string_ended_r;

    if (accept) begin
      if (is_term || (line_count_r >= CNT_LIMIT)) begin
        // End of line or overflow: start a fresh line.
        if (!is_term || (line_count_r != '0)) begin
          line_count_nxt   = '0;
          header_ok_nxt    = 1'b1;
          servo_digit_nxt  = 2'd0;
          phase_nxt        = scl_pkg::PH_SPACE;
          is_negative_nxt  = 1'b0;
          digit_value_nxt  = 8'd0;
          string_ended_nxt = 1'b0;
        end
      end else begin
        line_count_nxt = line_count_r + CNT_W'(1);
        if (c == scl_pkg::CH_NUL) begin
          string_ended_nxt = 1'b1;
        end
        if (line_count_r == CNT_W'(0)) begin
          if (c != scl_pkg::CH_S) begin
            header_ok_nxt = 1'b0;
          end
        end else if (line_count_r == CNT_W'(1)) begin
          if ((c < scl_pkg::CH_ONE) || (c > scl_pkg::CH_SERVO_HI)) begin
            header_ok_nxt = 1'b0;
          end else begin
            servo_digit_nxt = c[1:0];
          end
        end else if (line_count_r == CNT_W'(2)) begin
          if (c != scl_pkg::CH_COLON) begin
            header_ok_nxt = 1'b0;
          end
        end else if (!string_ended_r) begin
          unique case (phase_r)
            scl_pkg::PH_SPACE: begin
              if (!is_blank) begin
                if (c == scl_pkg::CH_PLUS) begin
                  phase_nxt = scl_pkg::PH_SIGNED;
                end else if (c == scl_pkg::CH_MINUS) begin
                  is_negative_nxt = 1'b1;
                  phase_nxt       = scl_pkg::PH_SIGNED;
                end else if (is_digit) begin
                  digit_value_nxt = digit_sat;
                  phase_nxt       = scl_pkg::PH_DIGITS;
                end else begin
                  phase_nxt = scl_pkg::PH_DONE;
                end
              end
            end
            scl_pkg::PH_SIGNED, scl_pkg::PH_DIGITS: begin
              if (is_digit) begin
                digit_value_nxt = digit_sat;
                phase_nxt       = scl_pkg::PH_DIGITS;
              end else begin
                phase_nxt = scl_pkg::PH_DONE;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r   <= '0;
      header_ok_r    <= 1'b1;
      servo_digit_r  <= 2'd0;
      phase_r        <= scl_pkg::PH_SPACE;
      is_negative_r  <= 1'b0;
      digit_value_r  <= 8'd0;
      string_ended_r <= 1'b0;
    end else begin
      line_count_r   <= line_count_nxt;
      header_ok_r    <= header_ok_nxt;
      servo_digit_r  <= servo_digit_nxt;
      phase_r        <= phase_nxt;
      is_negative_r  <= is_negative_nxt;
      digit_value_r  <= digit_value_nxt;
      string_ended_r <= string_ended_nxt;
    end
  end

  // Output buffer control; push never coincides with a held skid word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_servo_r <= skid_servo_r;
        out_angle_r <= skid_angle_r;
      end else if (push) begin
        out_servo_r <= servo_digit_r;
        out_angle_r <= res_angle;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_servo_r <= servo_digit_r;
        skid_angle_r <= res_angle;
      end else begin
        out_servo_r <= servo_digit_r;
        out_angle_r <= res_angle;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_angle_r, out_servo_r};

endmodule

// ===== dv/scl_checker.sv =====
`timescale 1ns / 100ps
// Checker for the servo command line parser: predicts servo commands and compares result words.
module scl_checker #(
  parameter int unsigned BUFFER_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          pending_cmds,
  output int          checked_cmds
);

  typedef struct packed {
    logic [1:0] servo;
    logic [7:0] angle;
  } servo_cmd_t;

  servo_cmd_t  cmd_q[$];

  // Line state mirrored from the byte stream.
  int unsigned     line_bytes;
  logic            hdr_ok;
  logic [1:0]      servo_sel;
  scl_pkg::phase_t phase;
  logic            neg;
  logic [7:0]      acc;
  logic            nul_seen;

  task automatic clear_line();
    line_bytes = 0;
    hdr_ok     = 1'b1;
    servo_sel  = '0;
    phase      = scl_pkg::PH_SPACE;
    neg        = 1'b0;
    acc        = '0;
    nul_seen   = 1'b0;
  endtask

  task automatic take_digit(input logic [7:0] c);
    int unsigned v;
    v = int'(acc) * 10 + int'(c - scl_pkg::CH_ZERO);
    // saturate instead of overflowing
    acc = (v > int'(scl_pkg::ANGLE_MAX)) ? scl_pkg::ANGLE_MAX : 8'(v);
  endtask

  task automatic read_number(input logic [7:0] c);
    logic is_dig;
    is_dig = (c >= scl_pkg::CH_ZERO) && (c <= scl_pkg::CH_NINE);
    case (phase)
      scl_pkg::PH_SPACE: begin
        if (c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB ||
            c == scl_pkg::CH_VT || c == scl_pkg::CH_FF) begin
          phase = scl_pkg::PH_SPACE;
        end else if (c == scl_pkg::CH_PLUS) begin
          phase = scl_pkg::PH_SIGNED;
        end else if (c == scl_pkg::CH_MINUS) begin
          neg   = 1'b1;
          phase = scl_pkg::PH_SIGNED;
        end else if (is_dig) begin
          take_digit(c);
          phase = scl_pkg::PH_DIGITS;
        end else begin
          phase = scl_pkg::PH_DONE;
        end
      end
      scl_pkg::PH_SIGNED, scl_pkg::PH_DIGITS: begin
        if (is_dig) begin
          take_digit(c);
          phase = scl_pkg::PH_DIGITS;
        end else begin
          phase = scl_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic collect_byte(input logic [7:0] c);
    if (c == scl_pkg::CH_NUL) nul_seen = 1'b1;
    if (line_bytes == 0) begin
      if (c != scl_pkg::CH_S) hdr_ok = 1'b0;
    end else if (line_bytes == 1) begin
      if (c < scl_pkg::CH_ONE || c > scl_pkg::CH_SERVO_HI) hdr_ok = 1'b0;
      else servo_sel = 2'(c - scl_pkg::CH_ZERO);
    end else if (line_bytes == 2) begin
      if (c != scl_pkg::CH_COLON) hdr_ok = 1'b0;
    end else if (!nul_seen) begin
      read_number(c);
    end
  endtask

  task automatic predict_byte(input logic [7:0] c);
    servo_cmd_t cmd;
    if (c == scl_pkg::CH_LF || c == scl_pkg::CH_CR) begin
      if (line_bytes > 0) begin
        if (hdr_ok && line_bytes >= 3) begin
          cmd.servo = servo_sel;
          cmd.angle = neg ? 8'd0 : acc;
          cmd_q.push_back(cmd);
        end
        clear_line();
      end
    end else if (line_bytes < BUFFER_SIZE - 1) begin
      collect_byte(c);
      line_bytes++;
    end else begin
      // overflow: drop the line and this byte
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    servo_cmd_t exp_cmd;
    int         bad;
    if (!rst_n) begin
      clear_line();
      cmd_q.delete();
      fail_count   = 0;
      checked_cmds = 0;
    end else begin
      // check the result word first: a result never stems from this edge's input
      if (out_tvalid && out_tready) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got servo %0d angle %0d",
                   $time, out_tdata[1:0], out_tdata[9:2]);
          fail_count++;
        end else begin
          exp_cmd = cmd_q.pop_front();
          bad     = 0;
          if (out_tdata[1:0] !== exp_cmd.servo) begin
            $display("%0t: servo_number mismatch, expected %0d, got %0d",
                     $time, exp_cmd.servo, out_tdata[1:0]);
            bad = 1;
          end
          if (out_tdata[9:2] !== exp_cmd.angle) begin
            $display("%0t: angle_value mismatch, expected %0d, got %0d",
                     $time, exp_cmd.angle, out_tdata[9:2]);
            bad = 1;
          end
          if (out_tdata[15:10] !== 6'd0) begin
            $display("%0t: pad bits mismatch, expected 0, got %0h", $time, out_tdata[15:10]);
            bad = 1;
          end
          fail_count += bad;
          checked_cmds++;
        end
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata);
    end
    pending_cmds = cmd_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the servo command line parser: byte stimulus, idling and verdict.
module tb;

  localparam int unsigned LINE_MAX     = 32;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          RANDOM_BYTES = 1050;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  int fail_count;
  int pending_cmds;
  int checked_cmds;
  int bytes_sent   = 0;
  int lines_sent   = 0;
  int idle_cycles  = 0;
  int drain_cycles = 0;
  int directed_bytes;
  bit eager        = 1'b0;

  logic [7:0] blanks [4] = '{scl_pkg::CH_SPACE, scl_pkg::CH_TAB, scl_pkg::CH_VT,
                             scl_pkg::CH_FF};

  always #2 clk = ~clk;

  servo_command_line_parser_core #(
    .BUFFER_SIZE(LINE_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  scl_checker #(
    .BUFFER_SIZE(LINE_MAX)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending_cmds(pending_cmds),
    .checked_cmds(checked_cmds)
  );

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_random_line();
    int         kind;
    int         pos;
    logic [7:0] term;
    logic [7:0] c;
    term = $urandom_range(0, 1) ? scl_pkg::CH_LF : scl_pkg::CH_CR;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // header (a servo digit out of range now and then), random number part
      send_byte(scl_pkg::CH_S);
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(scl_pkg::CH_ZERO, scl_pkg::CH_NINE)));
      end else begin
        send_byte(8'(scl_pkg::CH_ZERO + $urandom_range(1, scl_pkg::SERVO_COUNT)));
      end
      send_byte(scl_pkg::CH_COLON);
      repeat ($urandom_range(0, 2)) send_byte(blanks[$urandom_range(0, 3)]);
      case ($urandom_range(0, 5))
        0: send_byte(scl_pkg::CH_PLUS);
        1: send_byte(scl_pkg::CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) send_byte(8'(scl_pkg::CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      // corrupt one byte of an otherwise good line
      pos = $urandom_range(0, 5);
      for (int i = 0; i < 6; i++) begin
        case (i)
          0: c = scl_pkg::CH_S;
          1: c = 8'(scl_pkg::CH_ZERO + $urandom_range(1, scl_pkg::SERVO_COUNT));
          2: c = scl_pkg::CH_COLON;
          default: c = 8'(scl_pkg::CH_ZERO + $urandom_range(0, 9));
        endcase
        if (i == pos) c = $urandom_range(0, 1) ? scl_pkg::CH_NUL : 8'($urandom_range(0, 255));
        send_byte(c);
      end
    end else begin
      // long line, around the overflow point
      send_text("S2:");
      repeat ($urandom_range(28, 34)) send_byte(8'(scl_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    send_byte(term);
    lines_sent++;
  endtask

  // Result side: draw a stall per word, none while eager.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = eager ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed lines
    send_text("\n");
    send_text("\r");
    send_text("S1:\r");
    send_text("S\n");
    send_text("S1\n");
    send_text("S3:180\n");
    send_text("S2:0\r");
    send_text("S1:255\n");
    send_text("S2:-7\n");
    send_text("S3:+45\n");
    send_text("S1: \t\013\01490\n");
    send_text("S2:  -\n");
    send_text("S2:+-3\n");
    send_text("S3:12a34\n");
    send_text("S1:1 2\n");
    send_text("S1:12");
    send_byte(scl_pkg::CH_NUL);
    send_text("3\n");
    send_byte(scl_pkg::CH_S);
    send_byte(scl_pkg::CH_NUL);
    send_text("1:5\n");
    send_text("S0:5\n");
    send_text("S4:5\n");
    send_text("X1:5\n");
    send_text("S1;5\n");
    send_text("S1:");
    send_byte(8'hFF);
    send_text("\r");
    send_text("S1:7\r\n");
    // 31 bytes then a terminator: still a valid line
    send_text("S3:");
    repeat (27) send_byte(scl_pkg::CH_ZERO);
    send_byte(scl_pkg::CH_NINE);
    send_byte(scl_pkg::CH_LF);
    // 32nd byte overflows: line and byte dropped, next line starts clean
    send_text("S1:");
    repeat (28) send_byte(scl_pkg::CH_ZERO);
    send_text("5");
    send_text("S2:7\n");
    directed_bytes = bytes_sent;

    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) eager = ~eager;
      send_random_line();
    end
    in_tvalid = 1'b0;
    eager     = 1'b0;

    // drain outstanding words, bounded
    while (pending_cmds != 0 && drain_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (8) @(negedge clk);

    $display("sent %0d bytes in %0d random lines plus directed lines", bytes_sent, lines_sent);
    $display("checked %0d servo commands, %0d failures, %0d never seen",
             checked_cmds, fail_count, pending_cmds);
    if (fail_count == 0 && pending_cmds == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/scl_pkg.sv
rtl/core/servo_command_line_parser_core.sv
dv/scl_checker.sv
dv/tb.sv
